// ===== sv/thnc_pkg.sv =====
// Shared constants and types for the temporal history neighborhood clamp.
package thnc_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_WIDTH_DEF    = 2048;
    localparam int CHANNEL_BITS_DEF = 8;

    // Color channels per pixel and window columns in the chain
    localparam int NCH  = 3;
    localparam int NCOL = 3;

    // Configuration port
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;
    localparam int CFG_W    = 12;
    localparam int WEIGHT_W = 9;

    localparam logic [CFG_W-1:0]    WIDTH_RST  = 12'd1920;
    localparam logic [CFG_W-1:0]    HEIGHT_RST = 12'd1080;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RST = 9'd230;
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 9'd256;

    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_WEIGHT = 2'd2
    } t_reg_idx;

    // Output queue sizing: ready drops once the queue holds READY_LIMIT words,
    // which leaves room for everything still in the pipeline.
    localparam int FIFO_DEPTH  = 16;
    localparam int READY_LIMIT = 6;

    // Per-item control carried into the window stage
    typedef struct packed {
        logic first;   // column 0: window refills
        logic last;    // last column: a second result follows
        logic drain;   // drain item, lower row repeats the middle row
        logic row1;    // second row: upper row repeats the middle row
    } t_item_ctl;

    typedef struct packed {
        logic row_end;
        logic frame_end;
    } t_flags;

endpackage

// ===== sv/thnc_ram.sv =====
// Generic simple dual-port RAM with registered, read-first output.
module thnc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

// ===== sv/thnc_win_cell.sv =====
// One window column cell: holds the per-channel min/max of one 3-pixel column.
module thnc_win_cell #(
    parameter int CB = 8
) (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic                             i_sel_col,
    input  logic [thnc_pkg::NCH-1:0][CB-1:0] i_prev_lo,
    input  logic [thnc_pkg::NCH-1:0][CB-1:0] i_prev_hi,
    input  logic [thnc_pkg::NCH-1:0][CB-1:0] i_col_lo,
    input  logic [thnc_pkg::NCH-1:0][CB-1:0] i_col_hi,
    output logic [thnc_pkg::NCH-1:0][CB-1:0] o_lo,
    output logic [thnc_pkg::NCH-1:0][CB-1:0] o_hi
);
    import thnc_pkg::*;

    logic [NCH-1:0][CB-1:0] r_lo;
    logic [NCH-1:0][CB-1:0] r_hi;

    // take the fresh column or the neighbor's summary
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lo <= i_sel_col ? i_col_lo : i_prev_lo;
            r_hi <= i_sel_col ? i_col_hi : i_prev_hi;
        end
    end

    assign o_lo = r_lo;
    assign o_hi = r_hi;

endmodule

// ===== sv/thnc_blend.sv =====
// Clamp of history into the neighborhood range, then Q8 blend toward it.
module thnc_blend #(
    parameter int CB = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    input  logic [thnc_pkg::NCH-1:0][CB-1:0]      i_lo,
    input  logic [thnc_pkg::NCH-1:0][CB-1:0]      i_hi,
    input  logic [thnc_pkg::NCH-1:0][CB-1:0]      i_cur,
    input  logic [thnc_pkg::NCH-1:0][CB-1:0]      i_hist,
    input  thnc_pkg::t_flags                      i_flags,
    input  logic [thnc_pkg::WEIGHT_W-1:0]         i_weight,
    output logic                                  o_valid,
    output logic [thnc_pkg::NCH-1:0][CB-1:0]      o_color,
    output thnc_pkg::t_flags                      o_flags
);
    import thnc_pkg::*;

    localparam int PW = CB + 11;

    logic                   r_x_valid;
    logic [NCH-1:0][CB-1:0] r_x_h;
    logic [NCH-1:0][CB-1:0] r_x_cur;
    t_flags                 r_x_flags;

    logic [NCH-1:0][CB-1:0] w_h;
    logic [NCH-1:0][CB-1:0] w_mix;

    // stage 1: clamp
    always_comb begin
        for (int ch = 0; ch < NCH; ch++) begin
            w_h[ch] = (i_hist[ch] < i_lo[ch]) ? i_lo[ch] : i_hist[ch];
            if (w_h[ch] > i_hi[ch]) begin
                w_h[ch] = i_hi[ch];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_valid <= 1'b0;
        end else begin
            r_x_valid <= i_valid;
        end
        r_x_h     <= w_h;
        r_x_cur   <= i_cur;
        r_x_flags <= i_flags;
    end

    // stage 2: cur*256 + w*(h - cur) + 128, one multiply per channel
    always_comb begin
        logic signed [WEIGHT_W:0] wt;
        logic signed [CB:0]       diff;
        logic signed [PW-1:0]     prod;
        logic signed [PW-1:0]     base;
        logic signed [PW-1:0]     num;
        wt = $signed({1'b0, i_weight});
        for (int ch = 0; ch < NCH; ch++) begin
            diff      = $signed({1'b0, r_x_h[ch]}) - $signed({1'b0, r_x_cur[ch]});
            prod      = PW'(wt) * PW'(diff);
            base      = $signed({3'b000, r_x_cur[ch], 8'h80});
            num       = base + prod;
            w_mix[ch] = num[CB+7:8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_x_valid;
        end
        o_color <= w_mix;
        o_flags <= r_x_flags;
    end

endmodule

// ===== sv/thnc_ofifo.sv =====
// Small register-based output queue, one push and one pop per cycle.
module thnc_ofifo #(
    parameter int WIDTH = 26,
    parameter int DEPTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_data,
    input  logic                       i_pop,
    output logic [WIDTH-1:0]           o_data,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp;
    logic [AW-1:0]    r_rp;
    logic [CNTW-1:0]  r_count;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        ptr_inc = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= ptr_inc(r_wp);
            end
            if (i_pop) begin
                r_rp <= ptr_inc(r_rp);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rp];
    assign o_count = r_count;

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && !i_pop |-> r_count < CNTW'(DEPTH))
        else $error("output queue overflow");
`endif

endmodule

// ===== sv/temporal_history_neighborhood_clamp.sv =====
// Top level of the temporal history neighborhood clamp over a raster pixel stream.
//
// Input channel (i_valid/o_ready): one word per raster pixel with the current
// and history colors, or a drain word (i_op = 1) once all rows of a frame are in.
// A row of the frame yields its results while the next row arrives: the word
// at column c gives the result of column c-1 of the row above, and the last
// column gives two (the second marked row end). A drain row of frame_width
// words produces the last row, its final word marked frame end.
// Output channel (o_valid/i_ready): one blended pixel per word.
// Throughput: one input word per clock while o_ready is high. A result passes
// the line buffer read, window stage, clamp stage and blend stage in that
// order, then waits in the queue.
// A 16-word output queue parts the two sides; o_ready falls when it holds
// 6 words, which covers everything still in flight, so a stalled receiver
// stops the input before the queue fills, and the queue does not overflow.
// Words whose phase does not match (pixels while draining, drain words early)
// are taken and dropped. Reset clears counters, pipeline and queue and loads
// the default registers; line buffers are not cleared.
// Configuration (APB, pready always high): 0x0 frame_width, 0x4 frame_height,
// 0x8 history_weight, to be written only while the block is idle; the block does not enforce this.
module temporal_history_neighborhood_clamp #(
    parameter int MAX_WIDTH    = thnc_pkg::MAX_WIDTH_DEF,
    parameter int CHANNEL_BITS = thnc_pkg::CHANNEL_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // pixel input
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_op,
    input  logic [CHANNEL_BITS-1:0]       i_cur_red,
    input  logic [CHANNEL_BITS-1:0]       i_cur_green,
    input  logic [CHANNEL_BITS-1:0]       i_cur_blue,
    input  logic [CHANNEL_BITS-1:0]       i_hist_red,
    input  logic [CHANNEL_BITS-1:0]       i_hist_green,
    input  logic [CHANNEL_BITS-1:0]       i_hist_blue,
    // result output
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [CHANNEL_BITS-1:0]       o_out_red,
    output logic [CHANNEL_BITS-1:0]       o_out_green,
    output logic [CHANNEL_BITS-1:0]       o_out_blue,
    output logic                          o_row_end,
    output logic                          o_frame_end,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [thnc_pkg::ADDR_W-1:0]   paddr,
    input  logic [thnc_pkg::DATA_W-1:0]   pwdata,
    output logic [thnc_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import thnc_pkg::*;

    localparam int CB    = CHANNEL_BITS;
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int LW    = NCH * CB;
    localparam int RESW  = LW + 2;
    localparam int CNTW  = $clog2(FIFO_DEPTH + 1);

    // ---------------- configuration registers ----------------
    logic [CFG_W-1:0]    r_width;
    logic [CFG_W-1:0]    r_height;
    logic [WEIGHT_W-1:0] r_weight;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
            r_weight <= WEIGHT_RST;
        end else if (psel && penable && pwrite) begin
            case (t_reg_idx'(paddr[3:2]))
                REG_WIDTH: begin
                    r_width <= pwdata[CFG_W-1:0];
                end
                REG_HEIGHT: begin
                    r_height <= pwdata[CFG_W-1:0];
                end
                REG_WEIGHT: begin
                    r_weight <= pwdata[WEIGHT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (t_reg_idx'(paddr[3:2]))
            REG_WIDTH:  prdata = DATA_W'(r_width);
            REG_HEIGHT: prdata = DATA_W'(r_height);
            REG_WEIGHT: prdata = DATA_W'(r_weight);
            default:    prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // ---------------- raster position ----------------
    logic [CW-1:0]       r_col;
    logic [CFG_W-1:0]    r_row;
    logic [CW-1:0]       n_col;
    logic [CFG_W-1:0]    n_row;
    logic [CW-1:0]       w_wm1;      // last column index, width saturated to [2, MAX_WIDTH]
    logic [CW-1:0]       w_c;
    logic [CFG_W-1:0]    w_height;
    logic                w_last;
    logic                w_row0;
    logic                w_take;
    logic                w_in_acc;
    logic [WEIGHT_W-1:0] w_weight;

    always_comb begin
        if (r_width < CFG_W'(2)) begin
            w_wm1 = CW'(1);
        end else if (32'(r_width) > 32'(MAX_WIDTH)) begin
            w_wm1 = CW'(MAX_WIDTH - 1);
        end else begin
            w_wm1 = CW'(r_width - 1'b1);
        end
    end

    assign w_c      = (r_col >= w_wm1) ? w_wm1 : r_col;
    assign w_last   = (w_c == w_wm1);
    assign w_height = (r_height < CFG_W'(2)) ? CFG_W'(2) : r_height;
    assign w_row0   = (r_row == '0);
    assign w_in_acc = i_valid && o_ready;
    // words of the wrong phase are taken and dropped
    assign w_take   = w_in_acc && ((r_row >= w_height) == i_op);
    assign w_weight = (r_weight > WEIGHT_ONE) ? WEIGHT_ONE : r_weight;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (w_take) begin
            if (w_last) begin
                n_col = '0;
                if (w_row0) begin
                    n_row = CFG_W'(1);
                end else if (i_op) begin
                    n_row = '0;
                end else begin
                    n_row = r_row + 1'b1;
                end
            end else begin
                n_col = w_c + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // ---------------- line buffers ----------------
    logic [NCH-1:0][CB-1:0] w_cur;
    logic [NCH-1:0][CB-1:0] w_hist;
    logic [NCH-1:0][CB-1:0] w_mid_rd;
    logic [NCH-1:0][CB-1:0] w_up_rd;
    logic [NCH-1:0][CB-1:0] w_hl_rd;
    logic                   w_line_we;

    assign w_cur     = {i_cur_blue, i_cur_green, i_cur_red};
    assign w_hist    = {i_hist_blue, i_hist_green, i_hist_red};
    assign w_line_we = w_take && !i_op;

    // P1 stage: the word whose line data is now on the RAM outputs
    logic                   r_p1_valid;
    t_item_ctl              r_p1_ctl;
    logic [NCH-1:0][CB-1:0] r_p1_cur;
    logic [CW-1:0]          r_p1_addr;

    // middle row: read old, write the incoming pixel
    thnc_ram #(.WIDTH(LW), .DEPTH(MAX_WIDTH)) u_mid_line (
        .i_clk  (i_clk),
        .i_we   (w_line_we),
        .i_waddr(w_c),
        .i_wdata(w_cur),
        .i_re   (w_take),
        .i_raddr(w_c),
        .o_rdata(w_mid_rd)
    );

    // upper row: gets the old middle row in the cycle after it has been read
    thnc_ram #(.WIDTH(LW), .DEPTH(MAX_WIDTH)) u_up_line (
        .i_clk  (i_clk),
        .i_we   (r_p1_valid && !r_p1_ctl.drain),
        .i_waddr(r_p1_addr),
        .i_wdata(w_mid_rd),
        .i_re   (w_take),
        .i_raddr(w_c),
        .o_rdata(w_up_rd)
    );

    // history colors of the row above, center column
    thnc_ram #(.WIDTH(LW), .DEPTH(MAX_WIDTH)) u_hist_line (
        .i_clk  (i_clk),
        .i_we   (w_line_we),
        .i_waddr(w_c),
        .i_wdata(w_hist),
        .i_re   (w_take),
        .i_raddr(w_c),
        .o_rdata(w_hl_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
        end else begin
            r_p1_valid <= w_take && !w_row0;
        end
        r_p1_ctl.first <= (w_c == '0);
        r_p1_ctl.last  <= w_last;
        r_p1_ctl.drain <= i_op;
        r_p1_ctl.row1  <= (r_row == CFG_W'(1)) && !i_op;
        r_p1_cur       <= w_cur;
        r_p1_addr      <= w_c;
    end

    // ---------------- column summary and window chain ----------------
    function automatic logic [CB-1:0] min3(input logic [CB-1:0] a, b, c);
        logic [CB-1:0] m;
        m    = (a < b) ? a : b;
        min3 = (m < c) ? m : c;
    endfunction

    function automatic logic [CB-1:0] max3(input logic [CB-1:0] a, b, c);
        logic [CB-1:0] m;
        m    = (a > b) ? a : b;
        max3 = (m > c) ? m : c;
    endfunction

    logic [NCH-1:0][CB-1:0] w_s_lo;
    logic [NCH-1:0][CB-1:0] w_s_hi;
    logic [NCH-1:0][CB-1:0] w_win_lo   [NCOL];
    logic [NCH-1:0][CB-1:0] w_win_hi   [NCOL];
    logic [NCH-1:0][CB-1:0] w_prev_lo  [NCOL];
    logic [NCH-1:0][CB-1:0] w_prev_hi  [NCOL];
    logic                   w_sel_col  [NCOL];

    always_comb begin
        logic [CB-1:0] up;
        logic [CB-1:0] low;
        for (int ch = 0; ch < NCH; ch++) begin
            up         = r_p1_ctl.row1 ? w_mid_rd[ch] : w_up_rd[ch];
            low        = r_p1_ctl.drain ? w_mid_rd[ch] : r_p1_cur[ch];
            w_s_lo[ch] = min3(up, w_mid_rd[ch], low);
            w_s_hi[ch] = max3(up, w_mid_rd[ch], low);
        end
    end

    // Column 0 fills every cell with the new column; otherwise the chain shifts
    // toward cell 0. On the last column the newest column is also the right
    // neighbor of the final pixel, so cell NCOL-2 takes it too.
    always_comb begin
        for (int k = 0; k < NCOL; k++) begin
            if (k == NCOL - 1) begin
                w_prev_lo[k] = w_s_lo;
                w_prev_hi[k] = w_s_hi;
            end else begin
                w_prev_lo[k] = w_win_lo[k+1];
                w_prev_hi[k] = w_win_hi[k+1];
            end
            w_sel_col[k] = r_p1_ctl.first || (k == NCOL - 1)
                           || ((k == NCOL - 2) && r_p1_ctl.last);
        end
    end

    for (genvar k = 0; k < NCOL; k++) begin : g_win
        thnc_win_cell #(.CB(CB)) u_cell (
            .i_clk    (i_clk),
            .i_en     (r_p1_valid),
            .i_sel_col(w_sel_col[k]),
            .i_prev_lo(w_prev_lo[k]),
            .i_prev_hi(w_prev_hi[k]),
            .i_col_lo (w_s_lo),
            .i_col_hi (w_s_hi),
            .o_lo     (w_win_lo[k]),
            .o_hi     (w_win_hi[k])
        );
    end

    // ---------------- result operands ----------------
    // Result A: center = previous column (held), window = cells 1, 2 and new column.
    // Result B (last column only): center = this column, right edge replicated.
    logic                   w_a_valid;
    logic                   w_b_valid;
    logic [NCH-1:0][CB-1:0] w_a_lo;
    logic [NCH-1:0][CB-1:0] w_a_hi;
    logic [NCH-1:0][CB-1:0] w_b_lo;
    logic [NCH-1:0][CB-1:0] w_b_hi;

    logic [NCH-1:0][CB-1:0] r_hold_cur;
    logic [NCH-1:0][CB-1:0] r_hold_hist;

    logic                   r_e_valid;
    logic [NCH-1:0][CB-1:0] r_e_lo;
    logic [NCH-1:0][CB-1:0] r_e_hi;
    logic [NCH-1:0][CB-1:0] r_e_cur;
    logic [NCH-1:0][CB-1:0] r_e_hist;
    t_flags                 r_e_flags;

    logic                   r_pend_valid;
    logic [NCH-1:0][CB-1:0] r_pd_lo;
    logic [NCH-1:0][CB-1:0] r_pd_hi;
    logic [NCH-1:0][CB-1:0] r_pd_cur;
    logic [NCH-1:0][CB-1:0] r_pd_hist;
    t_flags                 r_pd_flags;

    assign w_a_valid = r_p1_valid && !r_p1_ctl.first;
    assign w_b_valid = r_p1_valid && r_p1_ctl.last;

    always_comb begin
        for (int ch = 0; ch < NCH; ch++) begin
            w_a_lo[ch] = min3(w_win_lo[1][ch], w_win_lo[2][ch], w_s_lo[ch]);
            w_a_hi[ch] = max3(w_win_hi[1][ch], w_win_hi[2][ch], w_s_hi[ch]);
            w_b_lo[ch] = (w_win_lo[2][ch] < w_s_lo[ch]) ? w_win_lo[2][ch] : w_s_lo[ch];
            w_b_hi[ch] = (w_win_hi[2][ch] > w_s_hi[ch]) ? w_win_hi[2][ch] : w_s_hi[ch];
        end
    end

    // The word after a last column is column 0, which gives no result A, so the
    // held result B always finds the operand register free in the next cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid    <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            r_e_valid    <= w_a_valid || r_pend_valid;
            r_pend_valid <= w_b_valid;
        end
        if (r_p1_valid) begin
            r_hold_cur  <= w_mid_rd;
            r_hold_hist <= w_hl_rd;
        end
        if (w_a_valid) begin
            r_e_lo    <= w_a_lo;
            r_e_hi    <= w_a_hi;
            r_e_cur   <= r_hold_cur;
            r_e_hist  <= r_hold_hist;
            r_e_flags <= '{row_end: 1'b0, frame_end: 1'b0};
        end else begin
            r_e_lo    <= r_pd_lo;
            r_e_hi    <= r_pd_hi;
            r_e_cur   <= r_pd_cur;
            r_e_hist  <= r_pd_hist;
            r_e_flags <= r_pd_flags;
        end
        if (w_b_valid) begin
            r_pd_lo    <= w_b_lo;
            r_pd_hi    <= w_b_hi;
            r_pd_cur   <= w_mid_rd;
            r_pd_hist  <= w_hl_rd;
            r_pd_flags <= '{row_end: 1'b1, frame_end: r_p1_ctl.drain};
        end
    end

    // ---------------- clamp and blend ----------------
    logic                   w_bl_valid;
    logic [NCH-1:0][CB-1:0] w_bl_color;
    t_flags                 w_bl_flags;

    thnc_blend #(.CB(CB)) u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_e_valid),
        .i_lo    (r_e_lo),
        .i_hi    (r_e_hi),
        .i_cur   (r_e_cur),
        .i_hist  (r_e_hist),
        .i_flags (r_e_flags),
        .i_weight(w_weight),
        .o_valid (w_bl_valid),
        .o_color (w_bl_color),
        .o_flags (w_bl_flags)
    );

    // ---------------- output queue ----------------
    logic [RESW-1:0] w_q_out;
    logic [CNTW-1:0] w_q_cnt;
    logic            w_pop;

    assign w_pop = o_valid && i_ready;

    thnc_ofifo #(.WIDTH(RESW), .DEPTH(FIFO_DEPTH)) u_ofifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_bl_valid),
        .i_data ({w_bl_flags, w_bl_color}),
        .i_pop  (w_pop),
        .o_data (w_q_out),
        .o_count(w_q_cnt)
    );

    assign o_valid     = (w_q_cnt != '0);
    assign o_ready     = (w_q_cnt < CNTW'(READY_LIMIT));
    assign o_out_red   = w_q_out[CB-1:0];
    assign o_out_green = w_q_out[2*CB-1:CB];
    assign o_out_blue  = w_q_out[3*CB-1:2*CB];
    assign o_row_end   = w_q_out[LW+1];
    assign o_frame_end = w_q_out[LW];

`ifndef SYNTHESIS
    a_pend_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_a_valid && r_pend_valid))
        else $error("held last-column result collides with a new result");

    a_last_gives_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p1_valid && r_p1_ctl.last |=> r_e_valid && r_pend_valid)
        else $error("last column did not produce two results");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (w_q_cnt == '0) && !r_p1_valid && !r_e_valid)
        else $error("pipeline not empty after reset");
`endif

endmodule
